// ===== rtl/i2c_mse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the I2C master sequence engine.
package i2c_mse_pkg;

	localparam int SEQ_DEPTH = 32;
	localparam int ADDR_W    = $clog2(SEQ_DEPTH);
	localparam int LEN_W     = $clog2(SEQ_DEPTH + 1);
	localparam int POS_W     = $clog2(SEQ_DEPTH + 2);
	localparam int ELEM_W    = 10;

	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_READ    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_DONE  = 2'd2,
		OP_ABORT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_WRITE   = 3'd2,
		ACT_RESTART = 3'd3,
		ACT_RECEIVE = 3'd4,
		ACT_READ    = 3'd5,
		ACT_STOP    = 3'd6,
		ACT_ERRSTOP = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_AVAILABLE = 2'd0,
		ST_BUSY      = 2'd1,
		ST_ERROR     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START_RD,
		S_START_EV,
		S_KIND_RD,
		S_KIND_EV,
		S_NEXT_RD,
		S_NEXT_EV,
		S_SCAN_RD,
		S_SCAN_EV,
		S_EMIT
	} state_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_out;
		logic       nack_next;
		logic       byte_stored;
		logic [7:0] received_byte;
		logic       sequence_done;
	} res_t;

endpackage

// ===== rtl/i2c_mse_chan_if.sv =====
`timescale 1ns / 1ps
// Command and response channel interfaces of the I2C master sequence engine.
interface i2c_mse_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [1:0] element_kind;
	logic [7:0] element_byte;
	logic       arbitration_lost;
	logic [7:0] data_in;

	modport source (
		output valid, operation, element_kind, element_byte, arbitration_lost, data_in,
		input  ready
	);
	modport sink (
		input  valid, operation, element_kind, element_byte, arbitration_lost, data_in,
		output ready
	);
endinterface

interface i2c_mse_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data_out;
	logic       nack_next;
	logic       byte_stored;
	logic [7:0] received_byte;
	logic [1:0] bus_status;
	logic       read_complete;
	logic       sequence_done;

	modport source (
		output valid, action, data_out, nack_next, byte_stored, received_byte,
		       bus_status, read_complete, sequence_done,
		input  ready
	);
	modport sink (
		input  valid, action, data_out, nack_next, byte_stored, received_byte,
		       bus_status, read_complete, sequence_done,
		output ready
	);
endinterface

// ===== rtl/i2c_mse_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module i2c_mse_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/i2c_master_sequence_engine.sv =====
`timescale 1ns / 1ps
// Load, abort and refused transactions pass from acceptance through the result register to
// the response register; a start first reads the first element from the sequence store; a
// transfer-done event may read the element at the current position and, after a restart, the
// one behind it, and when it opens a read run it reads ahead to count the further reads. The
// sequence store is a RAM with one registered read port that a small sequencer walks one
// element at a time. The engine takes one transaction at a time; a finished response waits
// in its own register while the next command is accepted.
module i2c_master_sequence_engine
	import i2c_mse_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	i2c_mse_cmd_if.sink   cmd,
	i2c_mse_rsp_if.source rsp
);

	state_t               state_q, state_d;
	logic [LEN_W-1:0]     length_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     ptr_q;
	logic [LEN_W-1:0]     rleft_q;
	logic                 receiving_q;
	status_t              status_q;
	logic                 rvf_q;
	logic                 out_valid_q;
	res_t                 res_q;
	res_t                 out_q;
	status_t              out_status_q;
	logic                 out_rvf_q;

	logic                 accept;
	op_t                  op;
	logic                 busy;
	logic                 load_ok;
	logic                 start_ok;
	logic                 pos_lt_len;
	logic                 inc_lt_len;
	logic [POS_W-1:0]     ptr_inc;
	logic                 slot_free;
	logic                 emit;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ELEM_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [ELEM_W-1:0]    ram_rdata;
	logic [1:0]           rd_kind;
	logic [7:0]           rd_byte;
	logic                 end_now;
	status_t              end_status;
	res_t                 res_acc;

	assign op         = op_t'(cmd.operation);
	assign busy       = (status_q == ST_BUSY);
	assign load_ok    = !busy && (length_q < LEN_W'(SEQ_DEPTH));
	assign start_ok   = !busy && (length_q != '0);
	assign pos_lt_len = (pos_q < POS_W'(length_q));
	assign ptr_inc    = ptr_q + POS_W'(1);
	assign inc_lt_len = (ptr_inc < POS_W'(length_q));
	assign rd_kind    = ram_rdata[9:8];
	assign rd_byte    = ram_rdata[7:0];
	assign slot_free  = !out_valid_q || rsp.ready;

	i2c_mse_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (SEQ_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EMIT;
					if (op == OP_START && start_ok && !cmd.arbitration_lost) begin
						state_d = S_START_RD;
					end else if (op == OP_DONE && busy && !cmd.arbitration_lost
					             && pos_lt_len) begin
						if (!receiving_q || rleft_q == '0) begin
							state_d = S_KIND_RD;
						end
					end
				end
			end
			S_START_RD: state_d = S_START_EV;
			S_START_EV: state_d = S_EMIT;
			S_KIND_RD:  state_d = S_KIND_EV;
			S_KIND_EV: begin
				if (rd_kind == KIND_RESTART && inc_lt_len) begin
					state_d = S_NEXT_RD;
				end else if (!receiving_q && rd_kind == KIND_READ && inc_lt_len) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_NEXT_RD:  state_d = S_NEXT_EV;
			S_NEXT_EV:  state_d = S_EMIT;
			S_SCAN_RD:  state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				if (rd_kind == KIND_READ && inc_lt_len) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready  = (state_q == S_IDLE);
		accept     = cmd.valid && (state_q == S_IDLE);
		emit       = (state_q == S_EMIT) && slot_free;
		ram_we     = accept && (op == OP_LOAD) && load_ok;
		ram_waddr  = length_q[ADDR_W-1:0];
		ram_wdata  = {cmd.element_kind, cmd.element_byte};
		ram_raddr  = ptr_q[ADDR_W-1:0];
		end_now    = 1'b0;
		end_status = ST_AVAILABLE;
		if (accept) begin
			unique case (op)
				OP_LOAD:  end_now = 1'b0;
				OP_START: end_now = start_ok && cmd.arbitration_lost;
				OP_DONE:  end_now = busy && (cmd.arbitration_lost
				                    || (!pos_lt_len && (!receiving_q || rleft_q == '0)));
				OP_ABORT: end_now = 1'b1;
				default:  end_now = 1'b0;
			endcase
			if (cmd.arbitration_lost && op != OP_ABORT) begin
				end_status = ST_ERROR;
			end
		end else if (state_q == S_KIND_EV) begin
			end_now = receiving_q && rd_kind != KIND_RESTART;
		end
	end

	always_comb begin
		res_acc = '{action: ACT_NONE, data_out: '0, nack_next: 1'b0,
		            byte_stored: 1'b0, received_byte: '0, sequence_done: 1'b0};
		case (op)
			OP_START: begin
				if (start_ok) begin
					res_acc.action = cmd.arbitration_lost ? ACT_ERRSTOP : ACT_START;
				end
			end
			OP_DONE: begin
				if (busy) begin
					if (cmd.arbitration_lost) begin
						res_acc.action = ACT_ERRSTOP;
					end else if (receiving_q) begin
						res_acc.byte_stored   = 1'b1;
						res_acc.received_byte = cmd.data_in;
						if (rleft_q != '0) begin
							res_acc.action    = ACT_READ;
							res_acc.nack_next = (rleft_q == LEN_W'(1));
						end else if (!pos_lt_len) begin
							res_acc.action        = ACT_STOP;
							res_acc.sequence_done = 1'b1;
						end
					end else if (!pos_lt_len) begin
						res_acc.action        = ACT_STOP;
						res_acc.sequence_done = 1'b1;
					end
				end
			end
			OP_ABORT: begin
				if (busy) begin
					res_acc.action = ACT_STOP;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			pos_q       <= '0;
			ptr_q       <= '0;
			rleft_q     <= '0;
			receiving_q <= 1'b0;
			status_q    <= ST_AVAILABLE;
			rvf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && op == OP_START && start_ok) begin
				rvf_q <= 1'b0;
			end else if (accept && op == OP_DONE && busy && !cmd.arbitration_lost
			             && receiving_q && rleft_q == '0) begin
				rvf_q <= 1'b1;
			end
			if (end_now) begin
				status_q    <= end_status;
				length_q    <= '0;
				pos_q       <= '0;
				receiving_q <= 1'b0;
				rleft_q     <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							unique case (op)
								OP_LOAD: begin
									if (load_ok) begin
										length_q <= length_q + LEN_W'(1);
									end
								end
								OP_START: begin
									if (start_ok) begin
										receiving_q <= 1'b0;
										rleft_q     <= '0;
										status_q    <= ST_BUSY;
										pos_q       <= POS_W'(1);
										ptr_q       <= '0;
									end
								end
								OP_DONE: begin
									if (busy && !cmd.arbitration_lost) begin
										if (receiving_q && rleft_q != '0) begin
											rleft_q <= rleft_q - LEN_W'(1);
											pos_q   <= pos_q + POS_W'(1);
										end else begin
											ptr_q <= pos_q;
										end
									end
								end
								OP_ABORT: ;
								default: ;
							endcase
						end
					end
					S_KIND_EV: begin
						ptr_q <= ptr_inc;
						if (rd_kind == KIND_RESTART) begin
							receiving_q <= 1'b0;
							pos_q       <= pos_q + POS_W'(2);
						end else if (!receiving_q) begin
							pos_q <= pos_q + POS_W'(1);
							if (rd_kind == KIND_READ) begin
								receiving_q <= 1'b1;
							end
						end
					end
					S_SCAN_EV: begin
						if (rd_kind == KIND_READ) begin
							rleft_q <= rleft_q + LEN_W'(1);
							ptr_q   <= ptr_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q        <= res_q;
			out_status_q <= status_q;
			out_rvf_q    <= rvf_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q <= res_acc;
				end
			end
			S_START_EV: res_q.data_out <= rd_byte;
			S_KIND_EV: begin
				if (rd_kind == KIND_RESTART) begin
					res_q.action   <= ACT_RESTART;
					res_q.data_out <= '0;
				end else if (receiving_q) begin
					res_q.action        <= ACT_STOP;
					res_q.sequence_done <= 1'b1;
				end else if (rd_kind == KIND_READ) begin
					res_q.action    <= ACT_RECEIVE;
					res_q.nack_next <= 1'b1;
				end else begin
					res_q.action   <= ACT_WRITE;
					res_q.data_out <= rd_byte;
				end
			end
			S_NEXT_EV: res_q.data_out <= rd_byte;
			S_SCAN_EV: begin
				if (rd_kind == KIND_READ) begin
					res_q.nack_next <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.action        = out_q.action;
	assign rsp.data_out      = out_q.data_out;
	assign rsp.nack_next     = out_q.nack_next;
	assign rsp.byte_stored   = out_q.byte_stored;
	assign rsp.received_byte = out_q.received_byte;
	assign rsp.bus_status    = out_status_q;
	assign rsp.read_complete = out_rvf_q;
	assign rsp.sequence_done = out_q.sequence_done;

endmodule

// ===== rtl/i2c_mse_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the I2C master sequence engine and their bind.
module i2c_mse_checker
	import i2c_mse_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_action,
	input logic       rsp_nack_next,
	input logic       rsp_byte_stored,
	input logic [1:0] rsp_bus_status,
	input logic       rsp_sequence_done
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while previous transaction still in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
		else $error("stalled response dropped or changed");

	a_done_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_sequence_done |->
			rsp_action == ACT_STOP && rsp_bus_status == ST_AVAILABLE)
		else $error("sequence done without a normal stop");

	a_stored_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_byte_stored |->
			rsp_action == ACT_READ || rsp_action == ACT_RESTART || rsp_action == ACT_STOP)
		else $error("received byte handed out on a transmit action");

	a_nack_on_receive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_nack_next |-> rsp_action == ACT_RECEIVE || rsp_action == ACT_READ)
		else $error("nack flag outside a receive action");

endmodule

bind i2c_master_sequence_engine i2c_mse_checker u_i2c_mse_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_action        (rsp.action),
	.rsp_nack_next     (rsp.nack_next),
	.rsp_byte_stored   (rsp.byte_stored),
	.rsp_bus_status    (rsp.bus_status),
	.rsp_sequence_done (rsp.sequence_done)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the I2C master sequence engine: queued commands, predicted responses.
module testbench;
	import i2c_mse_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * SEQ_DEPTH + 40;
	localparam int PHASE_ITEMS = 410;

	typedef struct packed {
		op_t        op;
		logic [1:0] kind;
		logic [7:0] ebyte;
		logic       arbl;
		logic [7:0] din;
	} cmd_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_out;
		logic       nack_next;
		logic       byte_stored;
		logic [7:0] received_byte;
		status_t    bus_status;
		logic       read_complete;
		logic       sequence_done;
	} outcome_t;

	typedef struct packed {
		logic [SEQ_DEPTH-1:0][ELEM_W-1:0] store;
		logic [LEN_W-1:0]                 length;
		logic [POS_W-1:0]                 pos;
		logic [LEN_W-1:0]                 reads_left;
		logic                             receiving;
		logic                             rd_valid;
		status_t                          status;
	} engine_t;

	logic clk;
	logic arst_n;

	i2c_mse_cmd_if cmd_bus ();
	i2c_mse_rsp_if rsp_bus ();

	i2c_master_sequence_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	cmd_t     pending_cmds[$];
	outcome_t expected_outcomes[$];
	engine_t  plan;
	engine_t  engine;

	int send_idle_pct;
	int recv_stall_pct;
	int cmd_offers;
	int cmd_accepts;
	int rsp_accepts;
	int holds_asked;
	int holds_served;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	int normal_stops;
	int error_stops;
	int bytes_received;
	int restarts;

	cmd_t     seen_cmd;
	outcome_t want;
	outcome_t got;

	function automatic logic [1:0] kind_at_pos(engine_t e, int p);
		if (p >= int'(e.length))
			return KIND_WRITE;
		return e.store[p][9:8];
	endfunction

	function automatic logic [7:0] byte_at_pos(engine_t e, int p);
		if (p >= int'(e.length))
			return 8'h00;
		return e.store[p][7:0];
	endfunction

	function automatic void close_sequence(inout engine_t e, input status_t s);
		e.status     = s;
		e.length     = '0;
		e.pos        = '0;
		e.receiving  = 1'b0;
		e.reads_left = '0;
	endfunction

	function automatic void sequencer_step(inout engine_t e, input cmd_t c, output outcome_t r);
		int n;
		logic [1:0] k;
		r.action        = ACT_NONE;
		r.data_out      = 8'h00;
		r.nack_next     = 1'b0;
		r.byte_stored   = 1'b0;
		r.received_byte = 8'h00;
		r.sequence_done = 1'b0;
		case (c.op)
			OP_LOAD: begin
				if (e.status != ST_BUSY && int'(e.length) < SEQ_DEPTH) begin
					e.store[e.length] = {c.kind, c.ebyte};
					e.length = e.length + 1'b1;
				end
			end
			OP_START: begin
				if (e.status != ST_BUSY && e.length != 0) begin
					e.rd_valid   = 1'b0;
					e.receiving  = 1'b0;
					e.reads_left = '0;
					if (c.arbl) begin
						r.action = ACT_ERRSTOP;
						close_sequence(e, ST_ERROR);
					end else begin
						e.status   = ST_BUSY;
						r.action   = ACT_START;
						r.data_out = byte_at_pos(e, 0);
						e.pos      = POS_W'(1);
					end
				end
			end
			OP_DONE: begin
				if (e.status == ST_BUSY) begin
					if (c.arbl) begin
						r.action = ACT_ERRSTOP;
						close_sequence(e, ST_ERROR);
					end else if (e.receiving) begin
						r.byte_stored   = 1'b1;
						r.received_byte = c.din;
						if (e.reads_left == 0) begin
							e.rd_valid = 1'b1;
							if (e.pos < e.length && kind_at_pos(e, int'(e.pos)) == KIND_RESTART) begin
								e.receiving = 1'b0;
								r.action    = ACT_RESTART;
								r.data_out  = byte_at_pos(e, int'(e.pos) + 1);
								e.pos       = e.pos + 2'd2;
							end else begin
								r.action        = ACT_STOP;
								r.sequence_done = 1'b1;
								close_sequence(e, ST_AVAILABLE);
							end
						end else begin
							r.action     = ACT_READ;
							r.nack_next  = (e.reads_left == 1);
							e.reads_left = e.reads_left - 1'b1;
							e.pos        = e.pos + 1'b1;
						end
					end else if (e.pos >= e.length) begin
						r.action        = ACT_STOP;
						r.sequence_done = 1'b1;
						close_sequence(e, ST_AVAILABLE);
					end else begin
						k = kind_at_pos(e, int'(e.pos));
						if (k == KIND_RESTART) begin
							r.action   = ACT_RESTART;
							r.data_out = byte_at_pos(e, int'(e.pos) + 1);
							e.pos      = e.pos + 2'd2;
						end else if (k == KIND_READ) begin
							n = 1;
							while (int'(e.pos) + n < int'(e.length)
							       && kind_at_pos(e, int'(e.pos) + n) == KIND_READ)
								n++;
							e.receiving  = 1'b1;
							r.action     = ACT_RECEIVE;
							r.nack_next  = (n == 1);
							e.reads_left = LEN_W'(n - 1);
							e.pos        = e.pos + 1'b1;
						end else begin
							r.action   = ACT_WRITE;
							r.data_out = byte_at_pos(e, int'(e.pos));
							e.pos      = e.pos + 1'b1;
						end
					end
				end
			end
			default: begin
				if (e.status == ST_BUSY)
					r.action = ACT_STOP;
				close_sequence(e, ST_AVAILABLE);
			end
		endcase
		r.bus_status    = e.status;
		r.read_complete = e.rd_valid;
	endfunction

	function automatic cmd_t make_cmd(op_t op, logic [1:0] kind, logic [7:0] ebyte,
	                                  logic arbl, logic [7:0] din);
		cmd_t c;
		c.op    = op;
		c.kind  = kind;
		c.ebyte = ebyte;
		c.arbl  = arbl;
		c.din   = din;
		return c;
	endfunction

	function automatic cmd_t any_cmd(op_t op);
		return make_cmd(op, 2'($urandom_range(3)), 8'($urandom_range(255)),
		                1'($urandom_range(1)), 8'($urandom_range(255)));
	endfunction

	function automatic void push_cmd(cmd_t c);
		outcome_t o;
		sequencer_step(plan, c, o);
		pending_cmds.push_back(c);
	endfunction

	function automatic string describe(outcome_t o);
		return $sformatf("act=%0d dout=%h nack=%b stored=%b rx=%h status=%0d rc=%b done=%b",
		                 o.action, o.data_out, o.nack_next, o.byte_stored, o.received_byte,
		                 o.bus_status, o.read_complete, o.sequence_done);
	endfunction

	function automatic void plan_sequences(int target);
		cmd_t c;
		int len;
		int guard;
		int pick;
		int queued;
		queued = 0;
		while (queued < target) begin
			if ($urandom_range(9) == 0) begin
				c = any_cmd(op_t'($urandom_range(3)));
				push_cmd(c);
				queued++;
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(SEQ_DEPTH + 2, 9) : $urandom_range(8, 1);
			for (int i = 0; i < len; i++) begin
				c = any_cmd(OP_LOAD);
				pick = $urandom_range(9);
				if (i == 0 && $urandom_range(9) != 0)
					c.kind = KIND_WRITE;
				else if (pick < 4)
					c.kind = KIND_WRITE;
				else if (pick < 7)
					c.kind = KIND_READ;
				else if (pick < 9)
					c.kind = KIND_RESTART;
				else
					c.kind = 2'd3;
				push_cmd(c);
				queued++;
			end
			c = any_cmd(OP_START);
			c.arbl = ($urandom_range(19) == 0);
			push_cmd(c);
			queued++;
			guard = 0;
			while (plan.status == ST_BUSY && guard < 3 * SEQ_DEPTH) begin
				pick = $urandom_range(99);
				if (pick < 3) begin
					c = any_cmd(OP_ABORT);
				end else if (pick < 7) begin
					c = any_cmd(op_t'($urandom_range(1)));
				end else begin
					c = any_cmd(OP_DONE);
					c.arbl = ($urandom_range(29) == 0);
				end
				push_cmd(c);
				queued++;
				guard++;
			end
		end
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver: offer the head of the queue, hold it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
		end else if (cmd_accepts == cmd_offers) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_bus.valid            <= 1'b1;
				cmd_bus.operation        <= pending_cmds[0].op;
				cmd_bus.element_kind     <= pending_cmds[0].kind;
				cmd_bus.element_byte     <= pending_cmds[0].ebyte;
				cmd_bus.arbitration_lost <= pending_cmds[0].arbl;
				cmd_bus.data_in          <= pending_cmds[0].din;
				cmd_offers++;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_bus.ready <= 1'b0;
			hold_left--;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on each command, check each response, watch for a stall
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (cmd_bus.valid && cmd_bus.ready) begin
				seen_cmd = make_cmd(op_t'(cmd_bus.operation), cmd_bus.element_kind,
				                    cmd_bus.element_byte, cmd_bus.arbitration_lost,
				                    cmd_bus.data_in);
				sequencer_step(engine, seen_cmd, want);
				expected_outcomes.push_back(want);
				void'(pending_cmds.pop_front());
				cmd_accepts++;
				quiet_cycles = 0;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.action        = action_t'(rsp_bus.action);
				got.data_out      = rsp_bus.data_out;
				got.nack_next     = rsp_bus.nack_next;
				got.byte_stored   = rsp_bus.byte_stored;
				got.received_byte = rsp_bus.received_byte;
				got.bus_status    = status_t'(rsp_bus.bus_status);
				got.read_complete = rsp_bus.read_complete;
				got.sequence_done = rsp_bus.sequence_done;
				rsp_accepts++;
				quiet_cycles = 0;
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response %0d with nothing outstanding: %s",
						         rsp_accepts, describe(got));
				end else begin
					want = expected_outcomes.pop_front();
					if (want.sequence_done)
						normal_stops++;
					if (want.action == ACT_ERRSTOP)
						error_stops++;
					if (want.action == ACT_RESTART)
						restarts++;
					if (want.byte_stored)
						bytes_received++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("response %0d expected %s", rsp_accepts, describe(want));
							$display("response %0d got      %s", rsp_accepts, describe(got));
						end
					end
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transaction for %0d cycles", QUIET_LIMIT);
				$display("FAIL i2c_master_sequence_engine");
				$finish;
			end
		end
	end

	initial begin
		arst_n                   = 1'b0;
		cmd_bus.valid            = 1'b0;
		cmd_bus.operation        = OP_LOAD;
		cmd_bus.element_kind     = KIND_WRITE;
		cmd_bus.element_byte     = 8'h00;
		cmd_bus.arbitration_lost = 1'b0;
		cmd_bus.data_in          = 8'h00;
		rsp_bus.ready            = 1'b0;
		send_idle_pct            = 0;
		recv_stall_pct           = 0;
		plan                     = '0;
		engine                   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'hFF));
		push_cmd(make_cmd(OP_START, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_ABORT, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_WRITE, 8'hFF, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, 2'd3, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_READ, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_READ, 8'hFF, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_RESTART, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_WRITE, 8'hA5, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_READ, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_START, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_WRITE, 8'h12, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_START, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'hFF));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'h5A));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'h81));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'hC3));
		push_cmd(make_cmd(OP_LOAD, KIND_WRITE, 8'h01, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_START, KIND_WRITE, 8'h00, 1'b1, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_WRITE, 8'h80, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_RESTART, 8'h7E, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_START, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_DONE, KIND_WRITE, 8'h00, 1'b1, 8'h00));
		push_cmd(make_cmd(OP_LOAD, KIND_WRITE, 8'h3C, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_START, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		push_cmd(make_cmd(OP_ABORT, KIND_WRITE, 8'h00, 1'b0, 8'h00));
		wait_drained();

		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			plan_sequences(PHASE_ITEMS);
			if (mode == 0)
				holds_asked++;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += expected_outcomes.size();
		$display("%0d commands and %0d responses over four pacing phases and one long hold-off",
		         cmd_accepts, rsp_accepts);
		$display("%0d normal stops, %0d error stops, %0d restarts, %0d bytes received, %0d mismatches",
		         normal_stops, error_stops, restarts, bytes_received, mismatches);
		if (mismatches == 0)
			$display("PASS i2c_master_sequence_engine");
		else
			$display("FAIL i2c_master_sequence_engine");
		$finish;
	end

endmodule
